@@ hw/rtl/trilinear_grid_sampler_core_defines.svh @@
// Assertion macros shared by the sampler RTL
`ifndef TRILINEAR_GRID_SAMPLER_CORE_DEFINES_SVH
`define TRILINEAR_GRID_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define TGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define TGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tgs_pkg.sv @@
// Types, register codes and helpers for the trilinear grid sampler
`timescale 1ns / 1ps
package tgs_pkg;

    localparam int CFG_ADDR_W = 5;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_CELLS = 3'd0,
        REG_ORG_X = 3'd1,
        REG_ORG_Y = 3'd2,
        REG_ORG_Z = 3'd3,
        REG_INV_X = 3'd4,
        REG_INV_Y = 3'd5,
        REG_INV_Z = 3'd6
    } t_reg_idx;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIFF  = 10'b00_0000_0010,
        S_MLO   = 10'b00_0000_0100,
        S_MHI   = 10'b00_0000_1000,
        S_SUM   = 10'b00_0001_0000,
        S_AWGT  = 10'b00_0010_0000,
        S_FETCH = 10'b00_0100_0000,
        S_LSUB  = 10'b00_1000_0000,
        S_LEND  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -51'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ hw/rtl/tgs_in_if.sv @@
// Input channel of the sampler: write and query beats
`timescale 1ns / 1ps
interface tgs_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [4:0]         node_i;
    logic [4:0]         node_j;
    logic [4:0]         node_k;
    logic signed [31:0] sample_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic               clamp_to_box;

    modport source (
        output valid, operation, node_i, node_j, node_k, sample_value,
               query_x, query_y, query_z, clamp_to_box,
        input  ready
    );
    modport sink (
        input  valid, operation, node_i, node_j, node_k, sample_value,
               query_x, query_y, query_z, clamp_to_box,
        output ready
    );
endinterface

@@ hw/rtl/tgs_out_if.sv @@
// Output channel of the sampler: interpolated result beats
`timescale 1ns / 1ps
interface tgs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interp_value;
    logic               outside;

    modport source (
        output valid, interp_value, outside,
        input  ready
    );
    modport sink (
        input  valid, interp_value, outside,
        output ready
    );
endinterface

@@ hw/rtl/tgs_ram.sv @@
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module tgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/trilinear_grid_sampler_core.sv @@
// Trilinear grid sampler top level: APB registers, sequencer and shared multiplier
//
// Holds a cubic grid of (MAX_CELLS+1)^3 signed Q16.16 samples in one single-port
// RAM and answers point queries by trilinear interpolation. A write beat gives no
// result. A query finds three axis positions and, unless the point is outside
// and clamping is off, seven lerps; each costs two passes through one shared
// 34x17 signed multiplier plus setup and sum steps, and the eight corner samples
// are read one per cycle from the RAM port. The input is not ready while a query
// is in work; a finished result waits in an output register so the next beat can
// be taken at once. Registers are to be written over APB only while the block is
// idle, which the block does not enforce; the store holds garbage until written.
`timescale 1ns / 1ps
`include "trilinear_grid_sampler_core_defines.svh"
module trilinear_grid_sampler_core #(
    parameter int MAX_CELLS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tgs_in_if.sink                        i_in,
    tgs_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tgs_pkg::*;

    localparam int NODES  = MAX_CELLS + 1;
    localparam int DEPTH  = NODES * NODES * NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(NODES);

    function automatic logic [ADDR_W-1:0] node_addr(
        input logic [IDX_W-1:0] x,
        input logic [IDX_W-1:0] y,
        input logic [IDX_W-1:0] z
    );
        logic [ADDR_W-1:0] zy;
        zy = ADDR_W'(ADDR_W'(z) * ADDR_W'(NODES)) + ADDR_W'(y);
        return ADDR_W'(zy * ADDR_W'(NODES)) + ADDR_W'(x);
    endfunction

    // configuration
    logic [4:0]         r_cells;
    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic [31:0]        r_inv_x, r_inv_y, r_inv_z;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= 5'd31;
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_inv_x <= 32'd65536;
            r_inv_y <= 32'd65536;
            r_inv_z <= 32'd65536;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_CELLS: r_cells <= pwdata[4:0];
                REG_ORG_X: r_org_x <= pwdata;
                REG_ORG_Y: r_org_y <= pwdata;
                REG_ORG_Z: r_org_z <= pwdata;
                REG_INV_X: r_inv_x <= pwdata;
                REG_INV_Y: r_inv_y <= pwdata;
                REG_INV_Z: r_inv_z <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_CELLS: prdata = 32'(r_cells);
            REG_ORG_X: prdata = r_org_x;
            REG_ORG_Y: prdata = r_org_y;
            REG_ORG_Z: prdata = r_org_z;
            REG_INV_X: prdata = r_inv_x;
            REG_INV_Y: prdata = r_inv_y;
            REG_INV_Z: prdata = r_inv_z;
            default:   prdata = '0;
        endcase
    end

    // datapath registers
    t_state              r_state;
    logic [1:0]          r_axis;
    logic [3:0]          r_fcnt;
    logic [2:0]          r_lcnt;
    logic                r_lerp;
    logic                r_oor;
    logic                r_clamp;
    logic                r_neg;
    logic signed [31:0]  r_qx, r_qy, r_qz;
    logic signed [33:0]  r_opa;
    logic signed [50:0]  r_prod;
    logic signed [65:0]  r_acc;
    logic [IDX_W-1:0]    r_ix, r_iy, r_iz;
    logic signed [31:0]  r_wx, r_wy, r_wz;
    logic signed [31:0]  r_c [8];
    logic                r_ovalid;
    logic signed [31:0]  r_ovalue;
    logic                r_oout;

    logic                w_in_hs;
    logic                w_out_load;
    logic [IDX_W-1:0]    w_res;
    logic signed [31:0]  w_q, w_org;
    logic signed [33:0]  w_d;
    logic [31:0]         w_b;
    logic signed [16:0]  w_blo, w_bhi;
    logic [31:0]         w_ih;
    logic [47:0]         w_u;
    logic                w_below, w_above;
    logic [IDX_W-1:0]    w_ic;
    logic signed [49:0]  w_wv;
    logic signed [31:0]  w_w;
    logic signed [50:0]  w_lsum;
    logic signed [31:0]  w_lres;
    logic [2:0]          w_code;
    logic                w_wr_ok;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_addr;
    logic [31:0]         w_ram_rdata;

    assign w_in_hs    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_ovalid || o_out.ready);

    assign w_res = (32'(r_cells) > 32'(MAX_CELLS)) ? IDX_W'(MAX_CELLS) : IDX_W'(r_cells);

    always_comb begin
        case (r_axis)
            2'd0:    begin w_q = r_qx; w_org = r_org_x; end
            2'd1:    begin w_q = r_qy; w_org = r_org_y; end
            default: begin w_q = r_qz; w_org = r_org_z; end
        endcase
    end
    assign w_d = 34'(w_q) - 34'(w_org);

    always_comb begin
        if (!r_lerp) begin
            case (r_axis)
                2'd0:    w_b = r_inv_x;
                2'd1:    w_b = r_inv_y;
                default: w_b = r_inv_z;
            endcase
        end else if (r_lcnt < 3'd4) begin
            w_b = r_wx;
        end else if (r_lcnt < 3'd6) begin
            w_b = r_wy;
        end else begin
            w_b = r_wz;
        end
    end
    assign w_blo = $signed({1'b0, w_b[15:0]});
    assign w_bhi = r_lerp ? $signed({w_b[31], w_b[31:16]}) : $signed({1'b0, w_b[31:16]});

    // axis position: index, range check, clamped index and weight
    assign w_ih    = r_acc[63:32];
    assign w_u     = r_acc[63:16];
    assign w_below = r_neg && (w_ih != '0);
    assign w_above = !w_below && ((r_neg ? 32'd0 : w_ih) >= 32'(w_res));
    always_comb begin
        if (r_neg || (w_res == '0)) begin
            w_ic = '0;
        end else if (w_above) begin
            w_ic = w_res - IDX_W'(1);
        end else begin
            w_ic = IDX_W'(w_ih);
        end
    end
    assign w_wv = r_neg ? -$signed({2'b00, w_u})
                        : $signed({2'b00, w_u}) - $signed(50'(w_ic) << 16);
    assign w_w  = sat32(51'(w_wv));

    // lerp finish: a + floor(p / 65536), saturated
    assign w_lsum = 51'(r_c[0]) + 51'($signed(r_acc[65:16]));
    assign w_lres = sat32(w_lsum);

    // RAM port
    assign w_code  = r_fcnt[2:0];
    assign w_wr_ok = (32'(i_in.node_i) <= 32'(MAX_CELLS)) &&
                     (32'(i_in.node_j) <= 32'(MAX_CELLS)) &&
                     (32'(i_in.node_k) <= 32'(MAX_CELLS));
    assign w_ram_we = w_in_hs && (i_in.operation == OP_WRITE) && w_wr_ok;
    always_comb begin
        if (r_state == S_IDLE) begin
            w_ram_addr = node_addr(IDX_W'(i_in.node_i), IDX_W'(i_in.node_j),
                                   IDX_W'(i_in.node_k));
        end else begin
            w_ram_addr = node_addr(r_ix + IDX_W'(w_code[0]), r_iy + IDX_W'(w_code[1]),
                                   r_iz + IDX_W'(w_code[2]));
        end
    end

    tgs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (i_in.sample_value),
        .o_rdata (w_ram_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_fcnt   <= '0;
            r_lcnt   <= '0;
            r_lerp   <= 1'b0;
            r_oor    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_hs && (i_in.operation == OP_QUERY)) begin
                        r_axis  <= '0;
                        r_oor   <= 1'b0;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_lerp  <= 1'b0;
                    r_state <= S_MLO;
                end
                S_MLO:  r_state <= S_MHI;
                S_MHI:  r_state <= S_SUM;
                S_SUM:  r_state <= r_lerp ? S_LEND : S_AWGT;
                S_AWGT: begin
                    r_oor <= r_oor || w_below || w_above;
                    if (r_axis == 2'd2) begin
                        r_fcnt <= '0;
                        if ((r_oor || w_below || w_above) && !r_clamp) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_DIFF;
                    end
                end
                S_FETCH: begin
                    r_fcnt <= r_fcnt + 4'd1;
                    if (r_fcnt == 4'd8) begin
                        r_lcnt  <= '0;
                        r_state <= S_LSUB;
                    end
                end
                S_LSUB: begin
                    r_lerp  <= 1'b1;
                    r_state <= S_MLO;
                end
                S_LEND: begin
                    if (r_lcnt == 3'd6) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lcnt  <= r_lcnt + 3'd1;
                        r_state <= S_LSUB;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_qx    <= i_in.query_x;
                r_qy    <= i_in.query_y;
                r_qz    <= i_in.query_z;
                r_clamp <= i_in.clamp_to_box;
            end
            S_DIFF: begin
                r_neg <= w_d[33];
                r_opa <= w_d[33] ? -w_d : w_d;
            end
            S_MLO: r_prod <= r_opa * w_blo;
            S_MHI: begin
                r_acc  <= 66'(r_prod);
                r_prod <= r_opa * w_bhi;
            end
            S_SUM: r_acc <= r_acc + (66'(r_prod) <<< 16);
            S_AWGT: begin
                case (r_axis)
                    2'd0:    begin r_ix <= w_ic; r_wx <= w_w; end
                    2'd1:    begin r_iy <= w_ic; r_wy <= w_w; end
                    default: begin r_iz <= w_ic; r_wz <= w_w; end
                endcase
            end
            S_FETCH: begin
                if (r_fcnt != '0) begin
                    for (int n = 0; n < 7; n++) begin
                        r_c[n] <= r_c[n+1];
                    end
                    r_c[7] <= w_ram_rdata;
                end
            end
            S_LSUB: r_opa <= 34'(r_c[1]) - 34'(r_c[0]);
            S_LEND: begin
                for (int n = 0; n < 6; n++) begin
                    if (n != int'(3'd6 - r_lcnt)) begin
                        r_c[n] <= r_c[n+2];
                    end
                end
                r_c[3'd6 - r_lcnt] <= w_lres;
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_oout   <= r_oor && !r_clamp;
            r_ovalue <= (r_oor && !r_clamp) ? VALUE_MAX : r_c[0];
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.interp_value = r_ovalue;
    assign o_out.outside      = r_oout;

    `TGS_ASSERT_NOW(a_outside_max, i_clk, i_rst_n, o_out.valid && o_out.outside, o_out.interp_value == VALUE_MAX, "outside result without max value")
    `TGS_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_in_hs && (i_in.operation == OP_QUERY), !i_in.ready, "ready after accepting a query")
    `TGS_ASSERT_NOW(a_fetch_bound, i_clk, i_rst_n, r_state == S_FETCH, r_fcnt <= 4'd8, "corner fetch count overrun")
    `TGS_ASSERT_NOW(a_lerp_bound, i_clk, i_rst_n, r_lerp && (r_state == S_MLO), r_lcnt <= 3'd6, "lerp count overrun")

endmodule

@@ bench/trilinear_grid_sampler_core_test.sv @@
// Self-checking bench for the trilinear grid sampler: APB setup, random beats, scoreboard
`timescale 1ns / 1ps
module trilinear_grid_sampler_core_test;
    import tgs_pkg::*;

    typedef struct {
        logic        op;
        logic [4:0]  ni, nj, nk;
        logic [31:0] sample;
        logic [31:0] qx, qy, qz;
        logic        clamp;
    } t_sampler_beat;

    typedef struct {
        logic [31:0] value;
        logic        outside;
    } t_sample_result;

    class sample_scoreboard;
        logic [31:0]    grid [32768];
        logic [4:0]     cells;
        logic [31:0]    org [3];
        logic [31:0]    inv [3];
        t_sample_result due [$];
        int             mismatches;
        int             results_seen;

        function new();
            cells = 5'd31;
            foreach (org[a]) begin
                org[a] = '0;
                inv[a] = 32'd65536;
            end
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_CELLS: cells = v[4:0];
                REG_ORG_X: org[0] = v;
                REG_ORG_Y: org[1] = v;
                REG_ORG_Z: org[2] = v;
                REG_INV_X: inv[0] = v;
                REG_INV_Y: inv[1] = v;
                REG_INV_Z: inv[2] = v;
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void cell_pos(logic [31:0] q, logic [31:0] o, logic [31:0] iv,
                               output longint u, output longint idx);
            longint   d;
            bit [63:0] mag;
            bit [63:0] p;
            d = longint'($signed(q)) - longint'($signed(o));
            mag = (d < 0) ? -d : d;
            p = mag * {32'd0, iv};
            u = longint'(p >> 16);
            idx = longint'(p >> 32);
            if (d < 0) begin
                u = -u;
                idx = -idx;
            end
        endfunction

        function longint blend(longint a, longint b, longint w);
            longint p;
            p = (b - a) * w;
            return clip32(a + (p >>> 16));
        endfunction

        function longint corner(longint i, longint j, longint k);
            return longint'($signed(grid[((k * 32 + j) * 32 + i) % 32768]));
        endfunction

        function void note_beat(t_sampler_beat b);
            longint u [3];
            longint ix [3];
            longint w [3];
            longint res;
            longint c00, c10, c01, c11, c0, c1;
            logic [31:0] q [3];
            bit out_of_grid;
            t_sample_result r;
            if (b.op == OP_WRITE) begin
                grid[(int'(b.nk) * 32 + int'(b.nj)) * 32 + int'(b.ni)] = b.sample;
                return;
            end
            res = longint'(cells);
            q[0] = b.qx;
            q[1] = b.qy;
            q[2] = b.qz;
            out_of_grid = 0;
            for (int a = 0; a < 3; a++) begin
                cell_pos(q[a], org[a], inv[a], u[a], ix[a]);
                if (ix[a] < 0 || ix[a] >= res) out_of_grid = 1;
            end
            if (!b.clamp && out_of_grid) begin
                r.value = VALUE_MAX;
                r.outside = 1'b1;
                due = {due, r};
                return;
            end
            for (int a = 0; a < 3; a++) begin
                if (ix[a] >= res) ix[a] = res - 1;
                if (ix[a] < 0) ix[a] = 0;
                w[a] = clip32(u[a] - ix[a] * 65536);
            end
            c00 = blend(corner(ix[0], ix[1], ix[2]), corner(ix[0] + 1, ix[1], ix[2]), w[0]);
            c10 = blend(corner(ix[0], ix[1] + 1, ix[2]),
                        corner(ix[0] + 1, ix[1] + 1, ix[2]), w[0]);
            c01 = blend(corner(ix[0], ix[1], ix[2] + 1),
                        corner(ix[0] + 1, ix[1], ix[2] + 1), w[0]);
            c11 = blend(corner(ix[0], ix[1] + 1, ix[2] + 1),
                        corner(ix[0] + 1, ix[1] + 1, ix[2] + 1), w[0]);
            c0 = blend(c00, c10, w[1]);
            c1 = blend(c01, c11, w[1]);
            r.value = 32'(blend(c0, c1, w[2]));
            r.outside = 1'b0;
            due = {due, r};
        endfunction

        function void check_result(logic [31:0] value, logic outside);
            t_sample_result e;
            results_seen++;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h outside=%b", value, outside);
                return;
            end
            e = due.pop_front();
            if (value !== e.value || outside !== e.outside) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%h outside=%b, got value=%h outside=%b",
                             e.value, e.outside, value, outside);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    tgs_in_if  in_ch ();
    tgs_out_if out_ch ();

    trilinear_grid_sampler_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sample_scoreboard sb = new();
    bit no_gaps = 0;
    int hold_left = 0;
    bit hold_done = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (!hold_done && sb.results_seen >= 300) begin
                hold_done = 1;
                hold_left = 400;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= no_gaps || ($urandom_range(99) >= 31);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.interp_value, out_ch.outside);
    end

    task automatic put_beat(t_sampler_beat b);
        while (!no_gaps && $urandom_range(99) < 31) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= b.op;
        in_ch.node_i       <= b.ni;
        in_ch.node_j       <= b.nj;
        in_ch.node_k       <= b.nk;
        in_ch.sample_value <= b.sample;
        in_ch.query_x      <= b.qx;
        in_ch.query_y      <= b.qy;
        in_ch.query_z      <= b.qz;
        in_ch.clamp_to_box <= b.clamp;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_beat(b);
    endtask

    task automatic write_node(int i, int j, int k, logic [31:0] v);
        t_sampler_beat b;
        b.op = OP_WRITE;
        b.ni = 5'(i);
        b.nj = 5'(j);
        b.nk = 5'(k);
        b.sample = v;
        b.qx = $urandom;
        b.qy = $urandom;
        b.qz = $urandom;
        b.clamp = 1'($urandom_range(1));
        put_beat(b);
    endtask

    task automatic ask_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic c);
        t_sampler_beat b;
        b.op = OP_QUERY;
        b.ni = 5'($urandom);
        b.nj = 5'($urandom);
        b.nk = 5'($urandom);
        b.sample = $urandom;
        b.qx = x;
        b.qy = y;
        b.qz = z;
        b.clamp = c;
        put_beat(b);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(logic [4:0] n, logic [31:0] ox, logic [31:0] oy,
                            logic [31:0] oz, logic [31:0] vx, logic [31:0] vy,
                            logic [31:0] vz);
        apb_write(REG_CELLS, 32'(n));
        apb_write(REG_ORG_X, ox);
        apb_write(REG_ORG_Y, oy);
        apb_write(REG_ORG_Z, oz);
        apb_write(REG_INV_X, vx);
        apb_write(REG_INV_Y, vy);
        apb_write(REG_INV_Z, vz);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] aim(int a);
        longint t;
        if (sb.inv[a] == 0 || $urandom_range(99) < 25) return $urandom;
        t = longint'($urandom_range((int'(sb.cells) + 2) * 65536)) - 65536;
        return 32'(longint'($signed(sb.org[a])) + (t * 65536) / longint'(sb.inv[a]));
    endfunction

    function automatic logic [31:0] any_sample();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_run(int n);
        for (int m = 0; m < n; m++) begin
            if ($urandom_range(99) < 30)
                write_node($urandom_range(31), $urandom_range(31), $urandom_range(31),
                           any_sample());
            else
                ask_point(aim(0), aim(1), aim(2), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_WRITE;
        in_ch.node_i = '0;
        in_ch.node_j = '0;
        in_ch.node_k = '0;
        in_ch.sample_value = '0;
        in_ch.query_x = '0;
        in_ch.query_y = '0;
        in_ch.query_z = '0;
        in_ch.clamp_to_box = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // keep at most seven cells per axis so every reachable node is filled
        set_grid(5'd7, 32'h0, 32'h0, 32'h0, 32'd65536, 32'd65536, 32'd65536);
        for (int k = 0; k < 8; k++)
            for (int j = 0; j < 8; j++)
                for (int i = 0; i < 8; i++)
                    write_node(i, j, k, any_sample());

        write_node(0, 0, 0, 32'h7FFF_FFFF);
        write_node(1, 0, 0, 32'h8000_0000);
        write_node(7, 7, 7, 32'h8000_0000);
        ask_point(32'h0, 32'h0, 32'h0, 1'b0);
        ask_point(32'h8000, 32'h8000, 32'h8000, 1'b0);
        ask_point(32'h0003_8000, 32'h0004_4000, 32'h0002_0001, 1'b0);
        ask_point(-32'sh100, 32'h8000, -32'sh1, 1'b0);
        ask_point(32'h0006_FFFF, 32'h0006_FFFF, 32'h0006_FFFF, 1'b0);
        ask_point(32'h0007_0000, 32'h0, 32'h0, 1'b0);
        ask_point(32'h0007_0000, 32'h0, 32'h0, 1'b1);
        ask_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        ask_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        ask_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        ask_point(32'h8000_0000, 32'h0, 32'h0, 1'b0);
        ask_point(-32'sh0001_0000, -32'sh0001_0000, 32'h0, 1'b1);
        random_run(200);
        drain();

        no_gaps = 1;
        set_grid(5'd7, 32'h0, 32'h0, 32'h0, 32'd65536, 32'd65536, 32'd65536);
        random_run(200);
        drain();
        no_gaps = 0;

        set_grid(5'd7, -32'sh0003_0000, 32'h0001_8000, -32'sh0000_0100,
                 32'd131072, 32'd98304, 32'd65536);
        random_run(250);
        drain();

        set_grid(5'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        random_run(200);
        drain();

        set_grid(5'd0, 32'h0, 32'h0, 32'h0, 32'd65536, 32'd65536, 32'd65536);
        random_run(150);
        drain();

        set_grid(5'd7, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_run(200);
        drain();

        set_grid(5'($urandom_range(1, 7)), $urandom_range(65536) - 32768,
                 $urandom_range(65536) - 32768, $urandom_range(65536) - 32768,
                 32'd32768, 32'd200000, 32'd5000);
        random_run(250);
        drain();

        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
